// ===== hw/rtl/equirectangular_distance_macros.svh =====
// ---------------------------------------------------------------------------
// Equirectangular distance assertion macros
// Property forms for the checker of the distance block.
// ---------------------------------------------------------------------------
`ifndef EQUIRECTANGULAR_DISTANCE_MACROS_SVH
`define EQUIRECTANGULAR_DISTANCE_MACROS_SVH

// check while out of reset
`define EDIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define EDIST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/edist_pkg.sv =====
// ---------------------------------------------------------------------------
// Equirectangular distance package
// Widths, constants, cosine table and square root step shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package edist_pkg;

  localparam int COS_TABLE_DEPTH = 1024;
  localparam int IDX_W           = $clog2(COS_TABLE_DEPTH);

  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DLAT_W = LAT_W + 1;
  localparam int DLON_W = LON_W + 1;
  localparam int SSUM_W = 24;
  localparam int COS_W  = 17;
  localparam int E_W    = DLON_W;
  localparam int SQ_W   = 56;
  localparam int ROOT_W = 27;
  localparam int DIST_W = 24;
  localparam int K_W    = 23;
  localparam int P_W    = K_W + ROOT_W;

  localparam int HALF_SPAN = 5898240;
  localparam int FULL_SPAN = 2 * HALF_SPAN;
  localparam int TURN_SPAN = 4 * HALF_SPAN;

  // index = (ssum * (depth - 1) + half) / full, full = 90 * 2^17
  localparam int NUM_W    = SSUM_W + IDX_W + 1;
  localparam int SPAN_SH  = 17;
  localparam int X_W      = NUM_W - SPAN_SH;
  localparam int RECIP_SH = 28;
  localparam int RECIP_W  = 22;
  localparam int RECIP    = ((1 << RECIP_SH) + 89) / 90;
  localparam int QP_W     = X_W + RECIP_W;
  localparam int Q_W      = QP_W - RECIP_SH;

  localparam int SQRT_STEPS     = 27;
  localparam int SQRT_PER_STAGE = 3;
  localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;
  localparam int SQRT_TOP_BIT   = 52;

  localparam int LATENCY = 9 + SQRT_STAGES;

  localparam longint unsigned K_WIDE =
    (64'd6371009 * 64'd31415926 * 64'd65536 + 64'd900000000000) / 64'd1800000000000;
  localparam logic [K_W-1:0] K_Q16 = K_W'(K_WIDE);

  localparam longint unsigned PI_Q30 = ((64'd31415926 << 30) + 64'd5000000) / 64'd10000000;
  localparam longint unsigned DEN    = 2 * (COS_TABLE_DEPTH - 1);
  localparam longint unsigned TAYLOR_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  typedef logic [COS_W-1:0] cos_tab_t [COS_TABLE_DEPTH];

  function automatic cos_tab_t build_cos_tab();
    cos_tab_t        tab;
    longint unsigned th;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      th   = (longint'(i) * PI_Q30 + DEN / 2) / DEN;
      x2   = (th * th + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
        if (k % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      tab[i] = COS_W'((longint'(sum) + (1 << 13)) >>> 14);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  typedef struct packed {
    logic [DLAT_W-1:0] dlat;
    logic [DLON_W-1:0] dlon;
    logic [COS_W-1:0]  c;
  } front_t;

  typedef struct packed {
    logic [SQ_W-1:0] s;
    logic [SQ_W-1:0] res;
  } root_t;

  function automatic root_t sqrt_step(root_t cur, logic [SQ_W-1:0] bitv);
    root_t           nxt;
    logic [SQ_W-1:0] trial;
    trial = cur.res + bitv;
    if (cur.s >= trial) begin
      nxt.s   = cur.s - trial;
      nxt.res = (cur.res >> 1) + bitv;
    end else begin
      nxt.s   = cur.s;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/edist_front.sv =====
// ---------------------------------------------------------------------------
// Distance front end
// Angle differences, mean latitude index and cosine lookup over four stages.
// ---------------------------------------------------------------------------
`default_nettype none

module edist_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  input  wire logic signed [edist_pkg::LAT_W-1:0]     src_lat,
  input  wire logic signed [edist_pkg::LON_W-1:0]     src_lon,
  input  wire logic signed [edist_pkg::LAT_W-1:0]     dst_lat,
  input  wire logic signed [edist_pkg::LON_W-1:0]     dst_lon,
  output logic                                        out_valid,
  output edist_pkg::front_t                           out_data
);
  import edist_pkg::*;

  logic signed [DLAT_W-1:0] lat_diff;
  logic signed [DLON_W-1:0] lon_diff;
  logic signed [DLAT_W-1:0] lat_sum;
  logic        [DLAT_W-1:0] sum_mag;
  logic        [DLAT_W-1:0] sum_mir;
  logic        [NUM_W-1:0]  num;
  logic        [QP_W-1:0]   qprod;
  logic        [IDX_W-1:0]  idx;

  logic [3:0]              v_r;
  logic [DLAT_W-1:0]       dlat1_r, dlat2_r, dlat3_r, dlat4_r;
  logic [DLON_W-1:0]       dlon1_r, dlon2_r, dlon3_r, dlon4_r;
  logic [SSUM_W-1:0]       ssum1_r;
  logic [X_W-1:0]          x2_r;
  logic [Q_W-1:0]          q3_r;
  logic [COS_W-1:0]        c4_r;

  always_comb begin
    lat_diff = DLAT_W'(dst_lat) - DLAT_W'(src_lat);
    lon_diff = DLON_W'(dst_lon) - DLON_W'(src_lon);
    lat_sum  = DLAT_W'(dst_lat) + DLAT_W'(src_lat);
    sum_mag  = lat_sum[DLAT_W-1] ? DLAT_W'(-lat_sum) : DLAT_W'(lat_sum);
    sum_mir  = (sum_mag > DLAT_W'(FULL_SPAN)) ? DLAT_W'(TURN_SPAN) - sum_mag : sum_mag;
    num      = NUM_W'(ssum1_r) * NUM_W'(COS_TABLE_DEPTH - 1) + NUM_W'(HALF_SPAN);
    qprod    = QP_W'(x2_r) * QP_W'(RECIP);
    idx      = (q3_r > Q_W'(COS_TABLE_DEPTH - 1)) ? IDX_W'(COS_TABLE_DEPTH - 1)
                                                   : q3_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    dlat1_r <= lat_diff[DLAT_W-1] ? DLAT_W'(-lat_diff) : DLAT_W'(lat_diff);
    dlon1_r <= lon_diff[DLON_W-1] ? DLON_W'(-lon_diff) : DLON_W'(lon_diff);
    ssum1_r <= sum_mir[SSUM_W-1:0];
    dlat2_r <= dlat1_r;
    dlon2_r <= dlon1_r;
    x2_r    <= num[NUM_W-1:SPAN_SH];
    dlat3_r <= dlat2_r;
    dlon3_r <= dlon2_r;
    q3_r    <= qprod[QP_W-1:RECIP_SH];
    dlat4_r <= dlat3_r;
    dlon4_r <= dlon3_r;
    c4_r    <= COS_TAB[idx];
  end

  assign out_valid     = v_r[3];
  assign out_data.dlat = dlat4_r;
  assign out_data.dlon = dlon4_r;
  assign out_data.c    = c4_r;

endmodule

`default_nettype wire

// ===== hw/rtl/edist_square.sv =====
// ---------------------------------------------------------------------------
// Distance squared sum
// Scale the longitude difference by the cosine and form the sum of squares.
// ---------------------------------------------------------------------------
`default_nettype none

module edist_square (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire edist_pkg::front_t           in_data,
  output logic                             out_valid,
  output logic [edist_pkg::SQ_W-1:0]       out_sum
);
  import edist_pkg::*;

  localparam int EP_W = COS_W + DLON_W;

  logic [EP_W-1:0]       eprod;
  logic [2:0]            v_r;
  logic [E_W-1:0]        e5_r;
  logic [2*DLAT_W-1:0]   dlat5_r, dlat6_r;
  logic [2*E_W-1:0]      e6_r;
  logic [SQ_W-1:0]       s7_r;

  assign eprod = EP_W'(in_data.c) * EP_W'(in_data.dlon) + EP_W'(1 << 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    e5_r    <= eprod[16 +: E_W];
    dlat5_r <= (2*DLAT_W)'(in_data.dlat) * (2*DLAT_W)'(in_data.dlat);
    e6_r    <= (2*E_W)'(e5_r) * (2*E_W)'(e5_r);
    dlat6_r <= dlat5_r;
    s7_r    <= SQ_W'(dlat6_r) + SQ_W'(e6_r);
  end

  assign out_valid = v_r[2];
  assign out_sum   = s7_r;

endmodule

`default_nettype wire

// ===== hw/rtl/edist_sqrt.sv =====
// ---------------------------------------------------------------------------
// Distance square root
// Bit-by-bit integer square root, three steps per pipeline stage.
// ---------------------------------------------------------------------------
`default_nettype none

module edist_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [edist_pkg::SQ_W-1:0]  in_sum,
  output logic                             out_valid,
  output logic [edist_pkg::ROOT_W-1:0]     out_root
);
  import edist_pkg::*;

  logic [SQRT_STAGES-1:0] v_r;
  root_t                  st_r [SQRT_STAGES];
  root_t                  st_in [SQRT_STAGES];
  root_t                  st_nxt [SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[SQRT_STAGES-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign st_in[g] = '{s: in_sum, res: '0};
    end else begin : g_rest
      assign st_in[g] = st_r[g-1];
    end

    always_comb begin
      root_t cur;
      cur = st_in[g];
      for (int n = 0; n < SQRT_PER_STAGE; n++) begin
        cur = sqrt_step(cur,
                        SQ_W'(1) << (SQRT_TOP_BIT - 2 * (g * SQRT_PER_STAGE + n)));
      end
      st_nxt[g] = cur;
    end

    always_ff @(posedge clk) begin
      st_r[g] <= st_nxt[g];
    end
  end

  assign out_valid = v_r[SQRT_STAGES-1];
  assign out_root  = st_r[SQRT_STAGES-1].res[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/edist_scale.sv =====
// ---------------------------------------------------------------------------
// Distance scale
// Convert the root in degrees to kilometers, round and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module edist_scale (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [edist_pkg::ROOT_W-1:0]  in_root,
  output logic                               out_valid,
  output logic [edist_pkg::DIST_W-1:0]       out_dist
);
  import edist_pkg::*;

  localparam int RND_W = P_W + 1;
  localparam int D_W   = RND_W - 24;

  logic [RND_W-1:0]  rnd;
  logic [D_W-1:0]    dist_full;
  logic [1:0]        v_r;
  logic [P_W-1:0]    p_r;
  logic [DIST_W-1:0] dist_r;

  always_comb begin
    rnd       = RND_W'(p_r) + RND_W'(1 << 23);
    dist_full = rnd[RND_W-1:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= P_W'(K_Q16) * P_W'(in_root);
    dist_r <= (dist_full > D_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : dist_full[DIST_W-1:0];
  end

  assign out_valid = v_r[1];
  assign out_dist  = dist_r;

endmodule

`default_nettype wire

// ===== hw/rtl/equirectangular_distance.sv =====
// ---------------------------------------------------------------------------
// Equirectangular distance
// Approximate surface distance between two points given in Q16 degrees.
// ---------------------------------------------------------------------------
// One point pair enters on every cycle that start is high; busy is high only
// during reset. Each result appears 18 cycles after its item for one cycle,
// marked by out_valid, and must be taken then: the receiver cannot stall.
// The latency is set by the 27-step square root, run three steps per stage
// over nine stages, between seven stages of differencing, cosine lookup and
// squaring and two stages of scaling. The cosine table is a constant array
// of 1024 entries.
`default_nettype none

module equirectangular_distance (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [edist_pkg::LAT_W-1:0]  in_src_lat,
  input  wire logic signed [edist_pkg::LON_W-1:0]  in_src_lon,
  input  wire logic signed [edist_pkg::LAT_W-1:0]  in_dst_lat,
  input  wire logic signed [edist_pkg::LON_W-1:0]  in_dst_lon,
  output logic                                     out_valid,
  output logic [edist_pkg::DIST_W-1:0]             out_distance_km
);
  import edist_pkg::*;

  logic            acc;
  logic            front_v;
  front_t          front_d;
  logic            sq_v;
  logic [SQ_W-1:0] sq_d;
  logic            root_v;
  logic [ROOT_W-1:0] root_d;

  assign busy = ~rst_n;
  assign acc  = start & ~busy;

  edist_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .src_lat   (in_src_lat),
    .src_lon   (in_src_lon),
    .dst_lat   (in_dst_lat),
    .dst_lon   (in_dst_lon),
    .out_valid (front_v),
    .out_data  (front_d)
  );

  edist_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_v),
    .in_data   (front_d),
    .out_valid (sq_v),
    .out_sum   (sq_d)
  );

  edist_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_sum    (sq_d),
    .out_valid (root_v),
    .out_root  (root_d)
  );

  edist_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_v),
    .in_root   (root_d),
    .out_valid (out_valid),
    .out_dist  (out_distance_km)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/edist_checker.sv =====
// ---------------------------------------------------------------------------
// Equirectangular distance checker
// Port-level timing checks of the distance pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "equirectangular_distance_macros.svh"

module edist_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                out_valid,
  input wire logic [edist_pkg::DIST_W-1:0]        out_distance_km
);
  import edist_pkg::*;

  logic acc;
  logic dist_seen;

  assign acc       = start & ~busy;
  assign dist_seen = ^out_distance_km | ~^out_distance_km;

  `EDIST_ASSERT(a_no_busy, (!busy), "busy high out of reset")
  `EDIST_ASSERT(a_latency, (acc |-> ##18 (out_valid && dist_seen)), "item result missing")
  `EDIST_ASSERT(a_no_extra, (out_valid |-> $past(acc, LATENCY)), "result without item")
  `EDIST_ASSERT_ALWAYS(a_reset_flush, (!rst_n |=> !out_valid), "result after reset")

endmodule

bind equirectangular_distance edist_checker u_edist_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_distance_km (out_distance_km)
);

`default_nettype wire
